>>> rtl/tzr_pkg.sv
// Shared types and constants for the triangle depth-buffer rasterizer.
`default_nettype none
package tzr_pkg;
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic signed [15:0] FAR_DEPTH = 16'sd32767;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [14:0] ax;
    logic signed [14:0] ay;
    logic signed [15:0] az;
    logic signed [14:0] bx;
    logic signed [14:0] by_coord;
    logic signed [15:0] bz;
    logic signed [14:0] cx;
    logic signed [14:0] cy;
    logic signed [15:0] cz;
    logic [7:0]         fill_char;
    logic [10:0]        cell_index;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_SETUP, ST_EDGE, ST_MUL, ST_SUM, ST_DIV, ST_RD,
    ST_CMP, ST_NEXT, ST_RDW, ST_RDO, ST_DONE
  } state_t;
endpackage
`default_nettype wire

>>> rtl/tzr_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module tzr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] addr,
  input  wire [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/tzr_front.sv
// Command front end: accepts commands into a two-entry queue.
`default_nettype none
module tzr_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  tzr_pkg::cmd_t       push_cmd,
  output logic                full,
  input  wire                 pop,
  output logic                avail,
  output tzr_pkg::cmd_t       head
);
  import tzr_pkg::*;
  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign head  = q_r[rp_r];
  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
    if (push) q_r[wp_r] <= push_cmd;
  end
endmodule
`default_nettype wire

>>> rtl/tzr_back.sv
// Command back end: clear sweep, triangle walk with depth test, cell read.
`default_nettype none
module tzr_back #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            avail,
  input  tzr_pkg::cmd_t  cmd,
  output logic           pop,
  output logic           idle,
  output logic           res_valid,
  output logic [7:0]     res_char,
  output logic [11:0]    res_count
);
  import tzr_pkg::*;
  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW = $clog2(CELLS);

  state_t st_r, st_nxt;
  cmd_t   c_r;
  logic signed [33:0] area_r;
  logic signed [10:0] x0_r, x1_r, y1_r, x_r, y_r;
  logic signed [33:0] w0_r, w1_r, w2_r;
  logic signed [50:0] p0_r, p1_r, p2_r;
  logic [52:0] rem_r, quo_r;
  logic [33:0] dvs_r;
  logic        neg_r;
  logic [5:0]  dcnt_r;
  logic signed [15:0] z_r;
  logic [11:0] count_r;
  logic [AW-1:0] clr_r;
  logic [7:0]  rchar_r;
  logic        boot_r;

  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wchar, char_q;
  logic [15:0]   wdep, dep_q;

  tzr_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_char (
    .clk(clk), .we(we), .addr(addr), .wdata(wchar), .rdata(char_q));
  tzr_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_dep (
    .clk(clk), .we(we), .addr(addr), .wdata(wdep), .rdata(dep_q));

  function automatic logic signed [33:0] edge_f(
    input logic signed [14:0] ax, input logic signed [14:0] ay,
    input logic signed [14:0] bx, input logic signed [14:0] by,
    input logic signed [15:0] px, input logic signed [15:0] py);
    logic signed [16:0] a, b, c, d;
    a = 17'(px) - 17'(ax); b = 17'(by) - 17'(ay);
    c = 17'(py) - 17'(ay); d = 17'(bx) - 17'(ax);
    return 34'(a * b) - 34'(c * d);
  endfunction

  function automatic logic signed [10:0] trq(input logic signed [14:0] v);
    logic [14:0] m;
    m = v[14] ? 15'(-v) : v;
    return v[14] ? -11'(m >> 4) : 11'(m >> 4);
  endfunction

  logic signed [14:0] mnx, mxx, mny, mxy;
  logic signed [10:0] tx0, ty0;
  logic signed [11:0] tx1, ty1;
  logic signed [15:0] px, py;
  logic signed [33:0] e0, e1, e2;
  logic covered;
  logic [53:0] trial;
  logic signed [53:0] zq;
  logic signed [52:0] num;

  always_comb begin
    mnx = c_r.ax; if (c_r.bx < mnx) mnx = c_r.bx; if (c_r.cx < mnx) mnx = c_r.cx;
    mxx = c_r.ax; if (c_r.bx > mxx) mxx = c_r.bx; if (c_r.cx > mxx) mxx = c_r.cx;
    mny = c_r.ay; if (c_r.by_coord < mny) mny = c_r.by_coord;
    if (c_r.cy < mny) mny = c_r.cy;
    mxy = c_r.ay; if (c_r.by_coord > mxy) mxy = c_r.by_coord;
    if (c_r.cy > mxy) mxy = c_r.cy;
    tx0 = trq(mnx); if (tx0 < 0) tx0 = '0;
    ty0 = trq(mny); if (ty0 < 0) ty0 = '0;
    tx1 = 12'(trq(mxx)) + 12'sd1;
    if (tx1 > 12'(SCREEN_WIDTH - 1)) tx1 = 12'(SCREEN_WIDTH - 1);
    ty1 = 12'(trq(mxy)) + 12'sd1;
    if (ty1 > 12'(SCREEN_HEIGHT - 1)) ty1 = 12'(SCREEN_HEIGHT - 1);
    px = {x_r[10], x_r, 4'b0};
    py = {y_r[10], y_r, 4'b0};
    e0 = edge_f(c_r.bx, c_r.by_coord, c_r.cx, c_r.cy, px, py);
    e1 = edge_f(c_r.cx, c_r.cy, c_r.ax, c_r.ay, px, py);
    e2 = edge_f(c_r.ax, c_r.ay, c_r.bx, c_r.by_coord, px, py);
    covered = (!w0_r[33] && !w1_r[33] && !w2_r[33]) ||
              ((w0_r[33] || w0_r == 0) && (w1_r[33] || w1_r == 0) &&
               (w2_r[33] || w2_r == 0));
    trial = {rem_r, quo_r[52]} - {20'b0, dvs_r};
    zq = neg_r ? -54'(quo_r) : 54'(quo_r);
    num = 53'(p0_r) + 53'(p1_r) + 53'(p2_r);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (avail) begin
        case (cmd.mode)
          MODE_CLEAR: st_nxt = ST_CLR;
          MODE_DRAW:  st_nxt = ST_SETUP;
          MODE_READ:  st_nxt = ST_RDW;
          default:    st_nxt = ST_DONE;
        endcase
      end
      ST_CLR:   if (clr_r == AW'(CELLS - 1)) st_nxt = boot_r ? ST_IDLE : ST_DONE;
      ST_SETUP: st_nxt = (area_r == 0 || tx0 > tx1 || ty0 > ty1) ? ST_DONE : ST_EDGE;
      ST_EDGE:  st_nxt = ST_MUL;
      ST_MUL:   st_nxt = covered ? ST_SUM : ST_NEXT;
      ST_SUM:   st_nxt = ST_DIV;
      ST_DIV:   if (dcnt_r == 6'd52) st_nxt = ST_RD;
      ST_RD:    st_nxt = ST_CMP;
      ST_CMP:   st_nxt = ST_NEXT;
      ST_NEXT:  st_nxt = (x_r == x1_r && y_r == y1_r) ? ST_DONE : ST_EDGE;
      ST_RDW:   st_nxt = ST_RDO;
      ST_RDO:   st_nxt = ST_DONE;
      ST_DONE:  st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  logic signed [15:0] zs;
  always_comb begin
    zs = (zq > 54'sd32767) ? 16'sd32767 : (zq < -54'sd32768) ? 16'sh8000 : 16'(zq);
    pop = (st_r == ST_IDLE) && avail;
    idle = (st_r == ST_IDLE);
    res_valid = (st_r == ST_DONE);
    res_char = rchar_r;
    res_count = count_r;
    we = 1'b0; wchar = c_r.fill_char; wdep = z_r;
    addr = AW'(32'(y_r) * SCREEN_WIDTH + 32'(x_r));
    case (st_r)
      ST_CLR: begin we = 1'b1; addr = clr_r; wchar = SPACE_CHAR; wdep = FAR_DEPTH; end
      ST_CMP: we = $signed(z_r) < $signed(dep_q);
      ST_RDW: addr = AW'(c_r.cell_index);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR; clr_r <= '0; count_r <= '0; rchar_r <= '0; boot_r <= 1'b1;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: begin
          c_r <= cmd; count_r <= '0; rchar_r <= '0; clr_r <= '0; boot_r <= 1'b0;
        end
        ST_CLR: clr_r <= clr_r + 1'b1;
        ST_CMP: if (we && count_r != 12'hfff) count_r <= count_r + 1'b1;
        ST_RDO: if (32'(c_r.cell_index) < CELLS) rchar_r <= char_q;
        default: ;
      endcase
    end
    case (st_r)
      ST_IDLE: area_r <= edge_f(cmd.ax, cmd.ay, cmd.bx, cmd.by_coord,
                                 16'(cmd.cx), 16'(cmd.cy));
      ST_SETUP: begin
        x0_r <= tx0; x1_r <= 11'(tx1); y1_r <= 11'(ty1); x_r <= tx0; y_r <= ty0;
      end
      ST_EDGE: begin w0_r <= e0; w1_r <= e1; w2_r <= e2; end
      ST_MUL: begin
        p0_r <= 51'(w0_r * c_r.az); p1_r <= 51'(w1_r * c_r.bz);
        p2_r <= 51'(w2_r * c_r.cz);
      end
      ST_SUM: begin
        neg_r <= num[52] ^ area_r[33];
        quo_r <= num[52] ? 53'(-num) : 53'(num);
        dvs_r <= area_r[33] ? 34'(-area_r) : 34'(area_r);
        rem_r <= '0; dcnt_r <= '0;
      end
      ST_DIV: begin
        dcnt_r <= dcnt_r + 1'b1;
        if (!trial[53]) begin
          rem_r <= trial[52:0]; quo_r <= {quo_r[51:0], 1'b1};
        end else begin
          rem_r <= {rem_r[51:0], quo_r[52]}; quo_r <= {quo_r[51:0], 1'b0};
        end
      end
      ST_RD: z_r <= zs;
      ST_NEXT: if (x_r == x1_r) begin x_r <= x0_r; y_r <= y_r + 1'b1; end
               else x_r <= x_r + 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/triangle_zbuffer_rasterizer.sv
// Top level of the triangle depth-buffer rasterizer.
// Usage: pulse start with a command while busy is low; the command is
// transferred into a two-entry queue. Each command yields exactly one
// result, shown for one cycle with out_valid high. The receiver cannot
// stall. Clear writes one cell per cycle through the RAM port. Draw
// walks the clamped bounding box of the triangle; each covered pixel
// also passes through the one-bit-per-cycle depth divider and a depth
// test. After reset a clearing pass over all SCREEN_WIDTH*SCREEN_HEIGHT
// cells runs before the first command starts; commands may queue
// meanwhile. Results leave in order.
`default_nettype none
module triangle_zbuffer_rasterizer #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire [1:0]         in_mode,
  input  wire signed [14:0] in_ax,
  input  wire signed [14:0] in_ay,
  input  wire signed [15:0] in_az,
  input  wire signed [14:0] in_bx,
  input  wire signed [14:0] in_by_coord,
  input  wire signed [15:0] in_bz,
  input  wire signed [14:0] in_cx,
  input  wire signed [14:0] in_cy,
  input  wire signed [15:0] in_cz,
  input  wire [7:0]         in_fill_char,
  input  wire [10:0]        in_cell_index,
  output logic              out_valid,
  output logic [7:0]        out_cell_char,
  output logic [11:0]       out_cells_written
);
  import tzr_pkg::*;
  cmd_t in_cmd, head;
  logic full, avail, pop, idle;
  assign in_cmd = '{in_mode, in_ax, in_ay, in_az, in_bx, in_by_coord, in_bz,
                    in_cx, in_cy, in_cz, in_fill_char, in_cell_index};
  assign busy = full;

  tzr_front u_front (
    .clk(clk), .rst_n(rst_n), .push(start && !full), .push_cmd(in_cmd),
    .full(full), .pop(pop), .avail(avail), .head(head));
  tzr_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk(clk), .rst_n(rst_n), .avail(avail), .cmd(head), .pop(pop), .idle(idle),
    .res_valid(out_valid), .res_char(out_cell_char), .res_count(out_cells_written));

  a_pop: assert property (@(posedge clk) disable iff (!rst_n) pop |-> avail && idle)
    else $error("pop without queued command");
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> avail) else $error("busy with empty queue");
endmodule
`default_nettype wire
